// ----- src/bti_pkg.sv -----
`default_nettype none
package bti_pkg;

  // table geometry
  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);

  // field and register widths
  localparam int DATA_W      = 32;
  localparam int SLOT_W      = 4;
  localparam int ENTRIES_W   = 5;
  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;

  // serial divider: quotient is known to fit one data word
  localparam int DIV_STEPS   = DATA_W;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

  // request commands
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  // register index, taken from paddr bit 2
  localparam logic REG_ENTRIES = 1'b0;
  localparam logic REG_MODE    = 1'b1;

endpackage
`default_nettype wire

// ----- src/bti_ram.sv -----
`default_nettype none
module bti_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- src/breakpoint_table_interpolator.sv -----
// write request: taken in IDLE, ready again on the next cycle, no result
// lookup request: result from CHK_FIRST at or below the first x, from CHK_LAST at or
//   above the last x, from a SCAN of the intervals for stair-step hold on interval i, and
//   from a single 32x32 multiply and a serial divide (MULT, DIV, ADJ) when interpolating
// one request at a time; the table ram read port sets the pace
// synchronous active-high reset: entries_in_use = 1, interpolate_mode = 1, table undefined
`default_nettype none
module breakpoint_table_interpolator (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // request channel
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                command,
  input  wire logic        [bti_pkg::SLOT_W-1:0]   entry_index,
  input  wire logic signed [bti_pkg::DATA_W-1:0]   x_value,
  input  wire logic signed [bti_pkg::DATA_W-1:0]   y_value,
  // result channel
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed      [bti_pkg::DATA_W-1:0]   result_y,
  // configuration port
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic        [bti_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic        [bti_pkg::APB_DATA_W-1:0] pwdata,
  output logic             [bti_pkg::APB_DATA_W-1:0] prdata,
  output logic                                     pready
);

  localparam int DW = bti_pkg::DATA_W;
  localparam int IW = bti_pkg::IDX_W;

  typedef enum logic [2:0] {
    IDLE, CHK_FIRST, CHK_LAST, SCAN, MULT, DIV, ADJ, FINISH
  } state_t;

  state_t state;

  // configuration registers
  logic [bti_pkg::ENTRIES_W-1:0] entries_in_use;
  logic                          interpolate_mode;

  // lookup working registers
  logic signed [DW-1:0]          q;
  logic signed [DW-1:0]          x_prev;
  logic signed [DW-1:0]          y_prev;
  logic signed [DW-1:0]          y_last;
  logic [IW-1:0]                 idx;
  logic [DW-1:0]                 off;     // query minus lower breakpoint
  logic [DW-1:0]                 dx;      // interval width, always positive
  logic [DW-1:0]                 mag;     // magnitude of the y step
  logic                          neg;     // y falls across the interval
  logic [DW-1:0]                 rem;     // divider remainder
  logic [DW-1:0]                 quo;     // product low half, becomes the quotient
  logic [bti_pkg::DIV_CNT_W-1:0] div_cnt;
  logic signed [DW-1:0]          res;

  // ---------------------------------------------------------------------------
  // configuration port: always ready, register index on paddr bit 2
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;

  always_comb begin
    unique case (paddr[2])
      bti_pkg::REG_ENTRIES: prdata = bti_pkg::APB_DATA_W'(entries_in_use);
      bti_pkg::REG_MODE:    prdata = bti_pkg::APB_DATA_W'(interpolate_mode);
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use   <= bti_pkg::ENTRIES_W'(1);
      interpolate_mode <= 1'b1;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        bti_pkg::REG_ENTRIES: entries_in_use <= pwdata[bti_pkg::ENTRIES_W-1:0];
        bti_pkg::REG_MODE:    interpolate_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  // last slot a lookup considers: zero counts as one, large counts saturate
  logic [IW-1:0] last_idx;

  always_comb begin
    if (entries_in_use == '0) begin
      last_idx = '0;
    end else if (32'(entries_in_use) > 32'(bti_pkg::MAX_ENTRIES)) begin
      last_idx = IW'(bti_pkg::MAX_ENTRIES - 1);
    end else begin
      last_idx = IW'(entries_in_use - bti_pkg::ENTRIES_W'(1));
    end
  end

  // ---------------------------------------------------------------------------
  // breakpoint table: x in the upper half of each word, y in the lower
  // ---------------------------------------------------------------------------
  logic              in_take;
  logic              tbl_we;
  logic [IW-1:0]     tbl_waddr;
  logic [IW-1:0]     tbl_raddr;
  logic [2*DW-1:0]   tbl_rdata;
  logic signed [DW-1:0] rd_x;
  logic signed [DW-1:0] rd_y;

  assign in_ready  = (state == IDLE);
  assign in_take   = in_valid && in_ready;
  // slots beyond the table are dropped
  assign tbl_we    = in_take && (command == bti_pkg::CMD_WRITE) &&
                     (32'(entry_index) < 32'(bti_pkg::MAX_ENTRIES));
  assign tbl_waddr = IW'(entry_index);
  assign rd_x      = tbl_rdata[2*DW-1:DW];
  assign rd_y      = tbl_rdata[DW-1:0];

  // read address is set in the state before the one that consumes the registered read data
  always_comb begin
    unique case (state)
      IDLE:      tbl_raddr = '0;
      CHK_FIRST: tbl_raddr = last_idx;
      CHK_LAST:  tbl_raddr = IW'(1);
      SCAN:      tbl_raddr = idx + IW'(1);
      default:   tbl_raddr = '0;
    endcase
  end

  bti_ram #(
    .WIDTH(2 * bti_pkg::DATA_W),
    .DEPTH(bti_pkg::MAX_ENTRIES)
  ) u_table (
    .clk  (clk),
    .we   (tbl_we),
    .waddr(tbl_waddr),
    .wdata({x_value, y_value}),
    .raddr(tbl_raddr),
    .rdata(tbl_rdata)
  );

  // ---------------------------------------------------------------------------
  // shared datapath pieces
  // ---------------------------------------------------------------------------
  logic              in_interval;
  logic [DW:0]       dx_full;
  logic [DW:0]       off_full;
  logic signed [DW:0] dy_full;
  logic [DW:0]       dy_mag;
  logic [2*DW-1:0]   prod;
  logic [DW+1:0]     trial;

  assign in_interval = (q >= x_prev) && (q < rd_x);
  assign dx_full     = (DW+1)'({rd_x[DW-1], rd_x} - {x_prev[DW-1], x_prev});
  assign off_full    = (DW+1)'({q[DW-1], q} - {x_prev[DW-1], x_prev});
  assign dy_full     = {rd_y[DW-1], rd_y} - {y_prev[DW-1], y_prev};
  assign dy_mag      = dy_full[DW] ? (DW+1)'(-dy_full) : (DW+1)'(dy_full);

  // single multiplier, registered straight into the divider
  assign prod        = (2*DW)'(off) * (2*DW)'(mag);

  // restoring divide step: remainder with the next dividend bit, less divisor
  assign trial       = {1'b0, rem, quo[DW-1]} - {2'b00, dx};

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      // output register: loaded from FINISH, emptied when the result is taken
      if (state == FINISH && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        IDLE: begin
          if (in_take && command == bti_pkg::CMD_LOOKUP) begin
            q     <= x_value;
            state <= CHK_FIRST;
          end
        end

        // entry 0 on the read port: clamp below the table
        CHK_FIRST: begin
          x_prev <= rd_x;
          y_prev <= rd_y;
          if (q <= rd_x) begin
            res   <= rd_y;
            state <= FINISH;
          end else begin
            state <= CHK_LAST;
          end
        end

        // last entry on the read port: clamp above the table
        CHK_LAST: begin
          y_last <= rd_y;
          idx    <= IW'(1);
          if (q >= rd_x) begin
            res   <= rd_y;
            state <= FINISH;
          end else begin
            state <= SCAN;
          end
        end

        // entry idx on the read port, entry idx-1 held in the prev registers
        SCAN: begin
          if (in_interval) begin
            if (interpolate_mode) begin
              off   <= off_full[DW-1:0];
              dx    <= dx_full[DW-1:0];
              mag   <= dy_mag[DW-1:0];
              neg   <= dy_full[DW];
              state <= MULT;
            end else begin
              res   <= y_prev;
              state <= FINISH;
            end
          end else if (idx == last_idx) begin
            // unsorted table, no interval matched
            res   <= y_last;
            state <= FINISH;
          end else begin
            x_prev <= rd_x;
            y_prev <= rd_y;
            idx    <= idx + IW'(1);
          end
        end

        // product high half is below dx, so the quotient fits one word
        MULT: begin
          rem     <= prod[2*DW-1:DW];
          quo     <= prod[DW-1:0];
          div_cnt <= '0;
          state   <= DIV;
        end

        DIV: begin
          if (!trial[DW+1]) begin
            rem <= trial[DW-1:0];
          end else begin
            rem <= {rem[DW-2:0], quo[DW-1]};
          end
          quo     <= {quo[DW-2:0], !trial[DW+1]};
          div_cnt <= div_cnt + bti_pkg::DIV_CNT_W'(1);
          if (div_cnt == bti_pkg::DIV_CNT_W'(bti_pkg::DIV_STEPS - 1)) begin
            state <= ADJ;
          end
        end

        // apply the sign of the y step to the truncated quotient
        ADJ: begin
          res   <= neg ? (y_prev - $signed(quo)) : (y_prev + $signed(quo));
          state <= FINISH;
        end

        // hand over once the output register is free
        FINISH: begin
          if (!out_valid || out_ready) begin
            result_y  <= res;
            state     <= IDLE;
          end
        end

        default: state <= IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  a_write_no_busy: assert property (@(posedge clk) disable iff (rst)
    (in_take && command == bti_pkg::CMD_WRITE) |=> in_ready)
    else $error("write request left the sequencer busy");

  a_lookup_busy: assert property (@(posedge clk) disable iff (rst)
    (in_take && command == bti_pkg::CMD_LOOKUP) |=> (state == CHK_FIRST))
    else $error("lookup request did not start a table walk");

  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    (state == SCAN) |-> (idx != '0 && idx <= last_idx))
    else $error("scan index outside the entries in use");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == DIV || state == ADJ) |-> (rem < dx))
    else $error("divider remainder not below the interval width");

  a_interp_path: assert property (@(posedge clk) disable iff (rst)
    (state == MULT) |-> $past(state == SCAN && interpolate_mode))
    else $error("multiply entered without a matched interval");

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
module testbench;

  // widths and sizes from the package
  localparam int DATA_W      = bti_pkg::DATA_W;
  localparam int SLOT_W      = bti_pkg::SLOT_W;
  localparam int ENTRIES_W   = bti_pkg::ENTRIES_W;
  localparam int APB_ADDR_W  = bti_pkg::APB_ADDR_W;
  localparam int APB_DATA_W  = bti_pkg::APB_DATA_W;
  localparam int MAX_ENTRIES = bti_pkg::MAX_ENTRIES;

  // run shape
  localparam int ITEMS          = 750;   // requests to offer in total
  localparam int HOLD_AT        = 300;   // request count at which the long result stall begins
  localparam int HOLD_CYCLES    = 500;   // length of that stall
  localparam int DRAIN_CYCLES   = 60;    // longest lookup latency with margin
  localparam int WATCHDOG_LIMIT = 5000;  // cycles with no handshake at all

  localparam longint X_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam longint X_MIN = -64'sh0000_0000_8000_0000;

  logic                        clk;
  logic                        rst;
  logic                        in_valid;
  logic                        in_ready;
  logic                        command;
  logic        [SLOT_W-1:0]    entry_index;
  logic signed [DATA_W-1:0]    x_value;
  logic signed [DATA_W-1:0]    y_value;
  logic                        out_valid;
  logic                        out_ready;
  logic signed [DATA_W-1:0]    result_y;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic        [APB_ADDR_W-1:0] paddr;
  logic        [APB_DATA_W-1:0] pwdata;
  logic        [APB_DATA_W-1:0] prdata;
  logic                        pready;

  // bookkeeping, written by the request driver only
  int req_count;
  int lookups_sent;
  int writes_sent;
  int reg_writes;
  int burst_left;

  // mirror of the breakpoint table and registers, plus the queue of predicted lookups
  class breakpoint_mirror;
    logic signed [DATA_W-1:0]    x_tbl [MAX_ENTRIES];
    logic signed [DATA_W-1:0]    y_tbl [MAX_ENTRIES];
    logic        [ENTRIES_W-1:0] entries;
    logic                        interp;
    logic signed [DATA_W-1:0]    pending_y [$];
    int                          mismatches;
    int                          checked;

    function new();
      entries    = 1;
      interp     = 1'b1;
      mismatches = 0;
      checked    = 0;
      foreach (x_tbl[k]) begin
        x_tbl[k] = '0;
        y_tbl[k] = '0;
      end
    endfunction

    // y0 + (q - x0) * (y1 - y0) / (x1 - x0), exact product, quotient towards zero
    function logic signed [DATA_W-1:0] blend_y(longint x0, longint y0, longint x1,
                                               longint y1, longint q);
      longint unsigned span;
      longint unsigned off;
      longint unsigned mag;
      longint unsigned quo;
      longint          dy;
      span = x1 - x0;
      off  = q - x0;
      dy   = y1 - y0;
      mag  = (dy < 0) ? -dy : dy;
      quo  = (off * mag) / span;
      return (dy < 0) ? DATA_W'(y0 - longint'(quo)) : DATA_W'(y0 + longint'(quo));
    endfunction

    function logic signed [DATA_W-1:0] lookup_y(logic signed [DATA_W-1:0] q);
      int n;
      int top;
      int i;
      n = int'(entries);
      if (n == 0) n = 1;
      if (n > MAX_ENTRIES) n = MAX_ENTRIES;
      top = n - 1;
      if (q <= x_tbl[0]) return y_tbl[0];
      if (q >= x_tbl[top]) return y_tbl[top];
      for (i = 1; i < n; i++) begin
        if (q >= x_tbl[i-1] && q < x_tbl[i]) begin
          if (interp)
            return blend_y(x_tbl[i-1], y_tbl[i-1], x_tbl[i], y_tbl[i], q);
          return y_tbl[i-1];
        end
      end
      return y_tbl[top];
    endfunction

    function void set_config(logic idx, logic [APB_DATA_W-1:0] val);
      if (idx == bti_pkg::REG_ENTRIES) entries = val[ENTRIES_W-1:0];
      else interp = val[0];
    endfunction

    function void note_request(logic cmd, logic [SLOT_W-1:0] slot,
                               logic signed [DATA_W-1:0] xv, logic signed [DATA_W-1:0] yv);
      if (cmd == bti_pkg::CMD_WRITE) begin
        x_tbl[slot] = xv;
        y_tbl[slot] = yv;
      end else begin
        pending_y.push_back(lookup_y(xv));
      end
    endfunction

    function void check_result(logic signed [DATA_W-1:0] got);
      logic signed [DATA_W-1:0] want;
      if (pending_y.size() == 0) begin
        mismatches++;
        $display("%0t: result_y %h arrived with no lookup outstanding", $time, got);
      end else begin
        want = pending_y.pop_front();
        checked++;
        if (got !== want) begin
          mismatches++;
          $display("%0t: result_y mismatch, expected %h, actual %h", $time, want, got);
        end
      end
    endfunction
  endclass

  breakpoint_mirror board;

  breakpoint_table_interpolator uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .command     (command),
    .entry_index (entry_index),
    .x_value     (x_value),
    .y_value     (y_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result_y    (result_y),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // 12 ns clock
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // random word biased towards the extremes and small magnitudes
  function automatic logic signed [DATA_W-1:0] rand_word();
    case ($urandom_range(0, 7)) inside
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      [2:3]: return $signed($urandom()) >>> $urandom_range(4, 28);
      default: return $urandom();
    endcase
  endfunction

  // sender pacing: bursts of random length, random gaps between them
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(0, 24);
    end
  endtask

  // offer one request and hold it until the block takes it
  task automatic send_req(input logic cmd, input logic [SLOT_W-1:0] slot,
                          input logic signed [DATA_W-1:0] xv,
                          input logic signed [DATA_W-1:0] yv);
    in_valid    <= 1'b1;
    command     <= cmd;
    entry_index <= slot;
    x_value     <= xv;
    y_value     <= yv;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_request(cmd, slot, xv, yv);
    req_count++;
    if (cmd == bti_pkg::CMD_LOOKUP) lookups_sent++;
    else writes_sent++;
    pace();
  endtask

  // stop offering, let every lookup come back, then let the block idle before the next phase
  task automatic settle();
    in_valid <= 1'b0;
    while (board.pending_y.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // apb write followed straight away by a read-back of the same register
  task automatic set_reg(input logic idx, input logic [APB_DATA_W-1:0] val);
    logic [APB_DATA_W-1:0] want;
    logic [APB_DATA_W-1:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    // register takes the value at this edge
    board.set_config(idx, val);
    reg_writes++;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    got     = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == bti_pkg::REG_ENTRIES) begin
      want = APB_DATA_W'(board.entries);
      got  = got & ((1 << ENTRIES_W) - 1);
    end else begin
      want = APB_DATA_W'(board.interp);
      got  = got & 1;
    end
    if (got !== want) begin
      board.mismatches++;
      $display("%0t: register %0d read-back mismatch, expected %h, actual %h",
               $time, idx, want, got);
    end
  endtask

  // result side: own stall pattern, one long hold-off to back the block up
  initial begin : result_sink
    int   style;
    int   style_left;
    int   hold_left;
    bit   held;
    logic rdy;
    style      = 0;
    style_left = 0;
    hold_left  = 0;
    held       = 1'b0;
    out_ready  = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) board.check_result(result_y);
      // long stall once the run is well under way, sender keeps pushing meanwhile
      if (!held && req_count >= HOLD_AT) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (style_left == 0) begin
        style      = $urandom_range(0, 3);
        style_left = $urandom_range(16, 96);
      end
      style_left--;
      case (style)
        0: rdy = 1'b1;
        1: rdy = 1'($urandom_range(0, 1));
        2: rdy = (style_left % 4 == 0);
        default: rdy = ($urandom_range(0, 7) != 0);
      endcase
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end
      out_ready <= rdy;
    end
  end

  // watchdog: any request, result or register access counts as progress
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || psel) quiet = 0;
      else quiet++;
    end
    $display("%0t: nothing accepted for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  // request driver and phase sequencing
  initial begin : stimulus
    int                       seg;
    int                       k;
    int                       k2;
    int                       pick;
    int                       n_eff;
    int                       nq;
    int                       step_sh;
    longint                   xpos;
    longint                   lo;
    longint                   hi;
    logic [ENTRIES_W-1:0]     ent_val;
    logic                     mode_val;
    logic signed [DATA_W-1:0] q;
    logic signed [DATA_W-1:0] xw;
    logic signed [DATA_W-1:0] yw;

    board        = new();
    req_count    = 0;
    lookups_sent = 0;
    writes_sent  = 0;
    reg_writes   = 0;
    burst_left   = 0;
    rst          = 1'b1;
    in_valid     = 1'b0;
    command      = bti_pkg::CMD_WRITE;
    entry_index  = '0;
    x_value      = '0;
    y_value      = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: fill every slot with a table spanning the whole x range
    for (k = 0; k < MAX_ENTRIES; k++) begin
      if (k == 0) begin
        xw = 32'h8000_0000;
        yw = 32'h7FFF_FFFF;
      end else if (k == MAX_ENTRIES - 1) begin
        xw = 32'h7FFF_FFFF;
        yw = 32'h8000_0000;
      end else begin
        xw = 32'(X_MIN + longint'(k) * 64'sh1000_0000);
        yw = k[0] ? $signed($urandom()) : (32'(k) <<< 20);
      end
      send_req(bti_pkg::CMD_WRITE, SLOT_W'(k), xw, yw);
    end
    // reset settings: a single entry, so both ends give the first y
    send_req(bti_pkg::CMD_LOOKUP, '1, 32'h0, 32'hFFFF_FFFF);
    send_req(bti_pkg::CMD_LOOKUP, '0, 32'h8000_0000, 32'h0);

    settle();
    set_reg(bti_pkg::REG_ENTRIES, 16);
    set_reg(bti_pkg::REG_MODE, 1);
    // ends, exact breakpoint, just below one, widest interval
    send_req(bti_pkg::CMD_LOOKUP, '0, 32'h8000_0000, '0);
    send_req(bti_pkg::CMD_LOOKUP, '1, 32'h7FFF_FFFF, '1);
    send_req(bti_pkg::CMD_LOOKUP, SLOT_W'(5), board.x_tbl[5], '0);
    send_req(bti_pkg::CMD_LOOKUP, SLOT_W'(9), board.x_tbl[5] - 1, '1);
    send_req(bti_pkg::CMD_LOOKUP, SLOT_W'(3), board.x_tbl[14] + 32'h0F00_0000,
             32'h5A5A_A5A5);

    // stair-step hold of the lower y
    settle();
    set_reg(bti_pkg::REG_MODE, 0);
    send_req(bti_pkg::CMD_LOOKUP, '0, board.x_tbl[3] + 5, '0);
    send_req(bti_pkg::CMD_LOOKUP, '1, board.x_tbl[14] + 7, '1);

    // random phases: new settings, fresh table contents, then a run of lookups
    seg = 0;
    while (req_count < ITEMS) begin
      case (seg)
        0: begin ent_val = 16; mode_val = 1'b0; end
        1: begin ent_val = 0;  mode_val = 1'b1; end
        2: begin ent_val = 31; mode_val = 1'b0; end
        3: begin ent_val = 17; mode_val = 1'b1; end
        default: begin
          case ($urandom_range(0, 7))
            0: ent_val = 1;
            1: ent_val = 2;
            2: ent_val = 16;
            3: ent_val = ENTRIES_W'($urandom());
            default: ent_val = ENTRIES_W'($urandom_range(3, 12));
          endcase
          mode_val = 1'($urandom());
        end
      endcase
      n_eff = (ent_val == 0) ? 1 : (ent_val > MAX_ENTRIES) ? MAX_ENTRIES : int'(ent_val);

      settle();
      set_reg(bti_pkg::REG_ENTRIES, APB_DATA_W'(ent_val));
      set_reg(bti_pkg::REG_MODE, APB_DATA_W'(mode_val));

      if ($urandom_range(0, 3) != 0) begin
        // ascending x with random spacing, repeats and saturation at the top allowed
        step_sh = $urandom_range(0, 27);
        xpos = ($urandom_range(0, 7) == 0) ? X_MIN :
               longint'($signed($urandom())) >>> $urandom_range(1, 4);
        for (k = 0; k < n_eff; k++) begin
          if (k > 0) xpos += longint'($urandom() >> (31 - step_sh));
          if (xpos > X_MAX) xpos = X_MAX;
          send_req(bti_pkg::CMD_WRITE, SLOT_W'(k), 32'(xpos), rand_word());
        end
      end else begin
        // unsorted table, some queries will find no interval
        for (k = 0; k < n_eff; k++)
          send_req(bti_pkg::CMD_WRITE, SLOT_W'(k), rand_word(), rand_word());
      end

      nq = $urandom_range(12, 30);
      for (k = 0; k < nq; k++) begin
        if ($urandom_range(0, 11) == 0) begin
          // stray write to any slot, may break the ordering
          send_req(bti_pkg::CMD_WRITE, SLOT_W'($urandom()), rand_word(), rand_word());
        end else begin
          pick = $urandom_range(0, n_eff - 1);
          case ($urandom_range(0, 9)) inside
            [0:5]: begin
              // somewhere inside an interval
              if (n_eff > 1) begin
                k2 = $urandom_range(1, n_eff - 1);
                lo = board.x_tbl[k2-1];
                hi = board.x_tbl[k2];
                if (hi > lo) q = 32'(lo + longint'($urandom_range(32'(hi - lo - 1), 0)));
                else q = 32'(lo);
              end else begin
                q = rand_word();
              end
            end
            6: q = board.x_tbl[pick];
            7: q = board.x_tbl[pick] + ($urandom_range(0, 1) ? 1 : -1);
            8: q = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: q = rand_word();
          endcase
          send_req(bti_pkg::CMD_LOOKUP, SLOT_W'($urandom()), q, $urandom());
        end
      end
      seg++;
    end

    settle();
    $display("%0d requests (%0d table writes, %0d lookups), %0d results checked, %0d register writes",
             req_count, writes_sent, lookups_sent, board.checked, reg_writes);
    $display("entry counts from zero to 31, both modes, sorted and unsorted tables, long result stall");
    if (board.mismatches == 0 && board.pending_y.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- files.f -----
src/bti_pkg.sv
src/bti_ram.sv
src/breakpoint_table_interpolator.sv
tb/testbench.sv
